// ===== sv/msgpack_object_boundary_scanner_unit_defines.svh =====
// Assertion macros shared by the checker of the MessagePack boundary scanner.
// Depends on nothing; each macro expects signals named clock and reset.
`ifndef MSGPACK_OBJECT_BOUNDARY_SCANNER_UNIT_DEFINES_SVH
`define MSGPACK_OBJECT_BOUNDARY_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MOBS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MOBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/mobs_pkg.sv =====
// Types and constants of the MessagePack object boundary scanner.
// Used by the step logic, the top level and the checker; depends on nothing.
package mobs_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_object;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        object_done;
      logic [31:0] pending_items;
   } rsp_type;

   localparam logic [1:0] ST_CONSUMED = 2'd0;
   localparam logic [1:0] ST_DONE     = 2'd1;
   localparam logic [1:0] ST_ERROR    = 2'd2;
   localparam logic [1:0] ST_REJECTED = 2'd3;

   typedef enum logic [5:0] {
      PH_TYPE   = 6'b000001,
      PH_DATA   = 6'b000010,
      PH_LEN    = 6'b000100,
      PH_EXTLEN = 6'b001000,
      PH_ARRCNT = 6'b010000,
      PH_MAPCNT = 6'b100000
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] items;
      logic [32:0] payload;
      logic [2:0]  prefix;
      logic        error;
   } scan_state_type;

   localparam scan_state_type SCAN_REARM = '{
      phase:   PH_TYPE,
      items:   32'd1,
      payload: 33'd0,
      prefix:  3'd0,
      error:   1'b0
   };

endpackage

// ===== sv/mobs_step.sv =====
// Combinational next-state and result logic for one stream word of the scanner.
// Depends on mobs_pkg for the word, result and state types.
module mobs_step import mobs_pkg::*; (
   input  req_type        req,
   input  scan_state_type state_cur,
   output scan_state_type state_next,
   output rsp_type        rsp
);

   localparam logic [7:0] BYTE_NEVER_USED = 8'hC1;

   scan_state_type cur;
   scan_state_type upd;
   logic [7:0]     b;
   logic [31:0]    shifted;
   logic [32:0]    add_n;
   logic [31:0]    add_base;
   logic [33:0]    sum;
   logic           do_add;
   logic           fail;
   logic           done;

   assign b = req.data_byte;

   always_comb begin
      cur = req.start_object ? SCAN_REARM : state_cur;
      upd = cur;
      shifted = {cur.payload[23:0], b};
      add_n = 33'd0;
      add_base = cur.items;
      do_add = 1'b0;
      fail = 1'b0;
      case (cur.phase)
         PH_DATA: begin
            upd.payload = cur.payload - 33'd1;
            if (upd.payload == 33'd0) begin
               upd.phase = PH_TYPE;
            end
         end
         PH_LEN, PH_EXTLEN, PH_ARRCNT, PH_MAPCNT: begin
            upd.payload = {1'b0, shifted};
            upd.prefix = cur.prefix - 3'd1;
            if (upd.prefix == 3'd0) begin
               case (cur.phase)
                  PH_LEN: begin
                     upd.phase = (shifted == 32'd0) ? PH_TYPE : PH_DATA;
                  end
                  PH_EXTLEN: begin
                     // The ext type byte is skipped along with the payload.
                     upd.payload = {1'b0, shifted} + 33'd1;
                     upd.phase = PH_DATA;
                  end
                  PH_ARRCNT: begin
                     add_n = {1'b0, shifted};
                     do_add = 1'b1;
                     upd.payload = 33'd0;
                     upd.phase = PH_TYPE;
                  end
                  default: begin
                     // A map of 2^31 pairs or more cannot be counted.
                     fail = shifted[31];
                     add_n = {shifted, 1'b0};
                     do_add = !shifted[31];
                     upd.payload = 33'd0;
                     upd.phase = PH_TYPE;
                  end
               endcase
            end
         end
         default: begin
            upd.phase = PH_TYPE;
            add_base = cur.items - 32'd1;
            upd.items = add_base;
            upd.payload = 33'd0;
            upd.prefix = 3'd0;
            if (b inside {[8'h80:8'h8F]}) begin
               add_n = {28'd0, b[3:0], 1'b0};
               do_add = 1'b1;
            end else if (b inside {[8'h90:8'h9F]}) begin
               add_n = {29'd0, b[3:0]};
               do_add = 1'b1;
            end else if (b inside {[8'hA0:8'hBF]}) begin
               upd.payload = {28'd0, b[4:0]};
               if (b[4:0] != 5'd0) begin
                  upd.phase = PH_DATA;
               end
            end else if (b == BYTE_NEVER_USED) begin
               fail = 1'b1;
            end else if (b inside {[8'hC4:8'hC6], [8'hD9:8'hDB]}) begin
               upd.prefix = (b == 8'hC4 || b == 8'hD9) ? 3'd1 :
                            (b == 8'hC5 || b == 8'hDA) ? 3'd2 : 3'd4;
               upd.phase = PH_LEN;
            end else if (b inside {[8'hC7:8'hC9]}) begin
               upd.prefix = (b == 8'hC7) ? 3'd1 : (b == 8'hC8) ? 3'd2 : 3'd4;
               upd.phase = PH_EXTLEN;
            end else if (b inside {[8'hCA:8'hCB]}) begin
               upd.payload = b[0] ? 33'd8 : 33'd4;
               upd.phase = PH_DATA;
            end else if (b inside {[8'hCC:8'hD3]}) begin
               upd.payload = 33'd1 << b[1:0];
               upd.phase = PH_DATA;
            end else if (b inside {[8'hD4:8'hD8]}) begin
               upd.payload = 33'd1 + (33'd1 << (b[2:0] - 3'd4));
               upd.phase = PH_DATA;
            end else if (b inside {[8'hDC:8'hDD]}) begin
               upd.prefix = b[0] ? 3'd4 : 3'd2;
               upd.phase = PH_ARRCNT;
            end else if (b inside {[8'hDE:8'hDF]}) begin
               upd.prefix = b[0] ? 3'd4 : 3'd2;
               upd.phase = PH_MAPCNT;
            end
            // Fixints, nil, booleans and negative fixints change nothing more.
         end
      endcase

      sum = {2'b00, add_base} + {1'b0, add_n};
      if (do_add) begin
         if (sum[33:32] != 2'b00) begin
            fail = 1'b1;
         end else begin
            upd.items = sum[31:0];
         end
      end
      done = (upd.phase == PH_TYPE) && (upd.items == 32'd0);

      if (cur.error) begin
         state_next = cur;
         rsp = '{status: ST_ERROR, object_done: 1'b0, pending_items: cur.items};
      end else if (cur.phase == PH_TYPE && cur.items == 32'd0) begin
         state_next = cur;
         rsp = '{status: ST_REJECTED, object_done: 1'b1, pending_items: 32'd0};
      end else if (fail) begin
         state_next = cur;
         state_next.error = 1'b1;
         rsp = '{status: ST_ERROR, object_done: 1'b0, pending_items: cur.items};
      end else begin
         state_next = upd;
         rsp = '{status: done ? ST_DONE : ST_CONSUMED, object_done: done,
                 pending_items: upd.items};
      end
   end

endmodule

// ===== sv/msgpack_object_boundary_scanner_unit.sv =====
// Top level of the MessagePack object boundary scanner: word and result
// registers around the step logic. Depends on mobs_pkg and mobs_step.

// The scanner takes a MessagePack stream one byte per word and reports, for
// every byte, whether it was consumed, whether it closed the current top-level
// object, or whether the stream is in error. It accepts one word every clock
// cycle with no bubbles while the result port is not stalled. Each result is
// presented on the result port after passing through the word register and
// then the result register. The rate is set by the scan state loop: pending
// item count, skip count and length-prefix count are read and rewritten in
// the same cycle by the step logic, so every byte sees the state left by the
// one before it. Raise start_object on the first byte of a new object to
// re-arm the scanner; this also clears a sticky error. Once an object is
// complete, further bytes are answered with the rejected status and leave the
// state alone. Reserved byte 0xC1 in a type position, a pending count past 32
// bits and a map header of 2^31 pairs or more all put the scanner into the
// error state.
module msgpack_object_boundary_scanner_unit import mobs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Word register.
   req_type        req_ff;
   logic           req_valid_ff;
   logic           req_valid_in;

   // Scan state, updated whenever a word moves into the result register.
   scan_state_type state_ff;
   scan_state_type state_in;

   // Result register.
   rsp_type        rsp_ff;
   rsp_type        rsp_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;

   logic           out_free;
   logic           advance;

   // The result register can take a new result when it is empty or is
   // being drained this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = req_valid_ff && out_free;

   // The word register stalls only when it holds a word that cannot move on.
   assign req_stall = req_valid_ff && !out_free;

   assign req_valid_in = req_valid ? 1'b1 : (req_valid_ff && !out_free);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);

   mobs_step u_step (
      .req        (req_ff),
      .state_cur  (state_ff),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= SCAN_REARM;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/mobs_checker.sv =====
// Port-level checker for the MessagePack object boundary scanner, and its bind.
// Depends on mobs_pkg and the assertion macros header.
`include "msgpack_object_boundary_scanner_unit_defines.svh"

module mobs_checker import mobs_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic rsp_is_done;
   logic rsp_is_rejected;
   logic rsp_is_error;

   assign rsp_is_done     = rsp_data.status == ST_DONE;
   assign rsp_is_rejected = rsp_data.status == ST_REJECTED;
   assign rsp_is_error    = rsp_data.status == ST_ERROR;

   // A stalled result stays put.
   `MOBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result changed while stalled")
   // The done flag follows the status code.
   `MOBS_ASSERT_IMPL(a_done_flag, rsp_valid, rsp_data.object_done == (rsp_is_done || rsp_is_rejected), "object_done disagrees with status")
   // A closed or complete object has nothing pending.
   `MOBS_ASSERT_IMPL(a_done_empty, rsp_valid && (rsp_is_done || rsp_is_rejected), rsp_data.pending_items == 32'd0, "pending items left on a finished object")
   // An error result never claims that the object is done.
   `MOBS_ASSERT_IMPL(a_err_not_done, rsp_valid && rsp_is_error, !rsp_data.object_done, "error result flagged as done")
   // The input only stalls while a result is waiting and the output is blocked.
   `MOBS_ASSERT_IMPL(a_stall_cause, req_stall, rsp_valid && rsp_stall, "input stalled with the output free")

endmodule

bind msgpack_object_boundary_scanner_unit mobs_checker u_checker (.*);
